### design/pru_pkg.sv
// Package for the pixel replicate upscaler: word types, field widths,
// kind and register codes, and limits. No dependencies.
package pru_pkg;

    localparam int PIX_W         = 24;
    localparam int FACTOR_W      = 7;
    localparam int WIDTH_W       = 11;
    localparam int FACTOR_MAX    = 100;
    localparam int WIDTH_MAX     = 1024;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // Register index as decoded from the byte address.
    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_PAD    = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic {
        MODE_FILL = 1'b0,
        MODE_EMIT = 1'b1
    } mode_t;

    typedef struct packed {
        logic       action;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
    } out_word_t;

    // Result decided at acceptance, waiting for the row store read.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  row_end;
        logic  use_pix;
    } slot_t;

endpackage

### design/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/pru_cfg.sv
// APB register file for the upscaler: scale factor and input width, with
// the clamped working values. Depends on pru_pkg.
module pru_cfg
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic [FACTOR_W-1:0] factor,
    output logic [WIDTH_W-1:0]  width
);

    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic                wr_stb;
    logic [WIDTH_W-1:0]  width_lim;

    assign wr_stb = psel && penable && pwrite;

    always_comb
    begin
        factor_next = factor_reg;
        width_next  = width_reg;
        if (wr_stb)
        begin
            unique case (paddr[2])
                REG_FACTOR: factor_next = pwdata[FACTOR_W-1:0];
                REG_WIDTH:  width_next  = pwdata[WIDTH_W-1:0];
                default:    factor_next = factor_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_W'(1);
            width_reg  <= WIDTH_W'(1);
        end
        else
        begin
            factor_reg <= factor_next;
            width_reg  <= width_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FACTOR: prdata = PDATA_W'(factor_reg);
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            default:    prdata = '0;
        endcase
    end

    // Out-of-range settings are pulled to the nearest legal value.
    always_comb
    begin
        priority if (factor_reg == '0)
            factor = FACTOR_W'(1);
        else if (32'(factor_reg) > FACTOR_MAX)
            factor = FACTOR_W'(FACTOR_MAX);
        else
            factor = factor_reg;
    end

    always_comb
    begin
        priority if (width_reg == '0)
            width_lim = WIDTH_W'(1);
        else if (32'(width_reg) > WIDTH_MAX)
            width_lim = WIDTH_W'(WIDTH_MAX);
        else
            width_lim = width_reg;
    end

    assign width = (32'(width_lim) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : width_lim;

endmodule

### design/pru_ctrl.sv
// Row sequencer: fill and emit counters, row store addressing and the
// per-word result decision. Depends on pru_pkg.
module pru_ctrl
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  in_word_t            item,
    input  logic [FACTOR_W-1:0] factor,
    input  logic [WIDTH_W-1:0]  width,
    output slot_t               slot,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [PIX_W-1:0]    wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr
);

    mode_t               mode_reg, mode_next;
    logic [WIDTH_W-1:0]  fill_reg, fill_next;
    logic [WIDTH_W-1:0]  src_reg, src_next;
    logic [FACTOR_W-1:0] copy_reg, copy_next;
    logic [FACTOR_W-1:0] rowc_reg, rowc_next;
    logic [1:0]          pad_reg, pad_next;

    logic [WIDTH_W:0]    fill_inc, src_inc;
    logic [FACTOR_W:0]   copy_inc, rowc_inc;
    logic                take_pixel, take_tick, pad_phase;
    logic                last_copy, last_src, row_last_pix, row_done;
    logic                fill_full, fill_in_store;
    logic [3:0]          pad_prod;
    logic [1:0]          pad_new;

    assign take_pixel = accept && (item.action == ACT_PIXEL) && (mode_reg == MODE_FILL);
    assign take_tick  = accept && (item.action == ACT_TICK) && (mode_reg == MODE_EMIT);
    assign pad_phase  = (pad_reg != '0);

    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign src_inc   = {1'b0, src_reg} + 1'b1;
    assign copy_inc  = {1'b0, copy_reg} + 1'b1;
    assign rowc_inc  = {1'b0, rowc_reg} + 1'b1;

    assign fill_full     = (fill_inc >= {1'b0, width});
    assign fill_in_store = (32'(fill_reg) < MAX_WIDTH);
    assign last_copy     = (copy_inc >= {1'b0, factor});
    assign last_src      = (src_inc >= {1'b0, width});

    // Three bytes per pixel: the pad to a four-byte boundary works out to
    // (width * factor) mod 4.
    assign pad_prod = width[1:0] * factor[1:0];
    assign pad_new  = pad_prod[1:0];

    assign row_last_pix = !pad_phase && last_copy && last_src;
    assign row_done     = take_tick && (pad_phase ? (pad_reg == 2'd1)
                                                  : (row_last_pix && pad_new == '0));

    // Next state.
    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        src_next  = src_reg;
        copy_next = copy_reg;
        rowc_next = rowc_reg;
        pad_next  = pad_reg;
        if (take_pixel)
        begin
            fill_next = fill_inc[WIDTH_W-1:0];
            if (fill_full)
            begin
                mode_next = MODE_EMIT;
                src_next  = '0;
                copy_next = '0;
                rowc_next = '0;
                pad_next  = '0;
            end
        end
        else if (take_tick)
        begin
            if (pad_phase)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (row_last_pix)
            begin
                pad_next = pad_new;
            end
            else if (last_copy)
            begin
                copy_next = '0;
                src_next  = src_inc[WIDTH_W-1:0];
            end
            else
            begin
                copy_next = copy_inc[FACTOR_W-1:0];
            end
            if (row_done)
            begin
                src_next  = '0;
                copy_next = '0;
                if (rowc_inc >= {1'b0, factor})
                begin
                    rowc_next = '0;
                    mode_next = MODE_FILL;
                    fill_next = '0;
                end
                else
                begin
                    rowc_next = rowc_inc[FACTOR_W-1:0];
                end
            end
        end
    end

    // Outputs.
    always_comb
    begin
        slot    = '0;
        wr_en   = take_pixel && fill_in_store;
        wr_addr = AW'(fill_reg);
        wr_data = {item.red, item.green, item.blue};
        rd_en   = 1'b0;
        rd_addr = AW'(src_reg);
        if (accept && (item.action == ACT_PIXEL) && (mode_reg == MODE_EMIT))
        begin
            slot.valid = 1'b1;
            slot.kind  = KIND_REJECT;
        end
        else if (take_tick)
        begin
            slot.valid   = 1'b1;
            slot.row_end = row_done;
            if (pad_phase)
            begin
                slot.kind = KIND_PAD;
            end
            else
            begin
                slot.kind    = KIND_PIXEL;
                slot.use_pix = (32'(src_reg) < MAX_WIDTH);
                rd_en        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FILL;
            fill_reg <= '0;
            src_reg  <= '0;
            copy_reg <= '0;
            rowc_reg <= '0;
            pad_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            src_reg  <= src_next;
            copy_reg <= copy_next;
            rowc_reg <= rowc_next;
            pad_reg  <= pad_next;
        end
    end

`ifndef SYNTHESIS
    a_pad_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != '0 |-> mode_reg == MODE_EMIT)
        else $error("pad bytes pending outside emit mode");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        take_pixel |-> fill_in_store)
        else $error("row store write beyond its depth");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(copy_reg) < FACTOR_MAX && 32'(rowc_reg) < FACTOR_MAX)
        else $error("copy counter out of range");
`endif

endmodule

### design/pru_out.sv
// Result pipeline: holds the decided word during the row store read, then
// the output register toward the result channel. Depends on pru_pkg.
module pru_out
    import pru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_t            slot,
    input  logic [PIX_W-1:0] rd_data,
    output logic             can_load,
    output logic             result_valid,
    input  logic             result_ready,
    output out_word_t        result
);

    slot_t     s1_reg, s1_next;
    logic      res_valid_reg, res_valid_next;
    out_word_t res_reg, res_next;
    logic      s1_move;

    assign s1_move  = s1_reg.valid && (!res_valid_reg || result_ready);
    assign can_load = !s1_reg.valid || s1_move;

    always_comb
    begin
        s1_next        = can_load ? slot : s1_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (s1_move)
        begin
            res_valid_next     = 1'b1;
            res_next.kind      = s1_reg.kind;
            res_next.out_blue  = s1_reg.use_pix ? rd_data[7:0]   : 8'h00;
            res_next.out_green = s1_reg.use_pix ? rd_data[15:8]  : 8'h00;
            res_next.out_red   = s1_reg.use_pix ? rd_data[23:16] : 8'h00;
            res_next.row_end   = s1_reg.row_end;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= s1_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && res_valid_reg && !result_ready |=> s1_reg.valid)
        else $error("pending word lost while output stalled");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == KIND_REJECT |->
            res_reg.row_end == 1'b0 && res_reg.out_red == 8'h00 &&
            res_reg.out_green == 8'h00 && res_reg.out_blue == 8'h00)
        else $error("reject word carries pixel data");
`endif

endmodule

### design/pixel_replicate_upscaler.sv
// Top level of the pixel replicate upscaler: register file, row sequencer,
// row store and result pipeline. Depends on pru_pkg and all pru_* modules.
//
// The block takes one word per clock while item_ready is high. Pixel
// words are written into the row store until the configured width is
// reached; from then on each tick word yields one output word. A result
// passes the staging register, which holds it during the registered row
// store read, and then the output register. Words are taken at one per
// clock as long as the result channel keeps up; the output register plus
// one staging register absorb a stall without losing a word. The row
// store needs no clearing after reset.
module pixel_replicate_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  in_word_t           item,
    output logic               result_valid,
    input  logic               result_ready,
    output out_word_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [FACTOR_W-1:0] factor;
    logic [WIDTH_W-1:0]  width;
    logic                accept;
    slot_t               slot;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [PIX_W-1:0]    wr_data, rd_data;

    assign pready = 1'b1;
    assign accept = item_valid && item_ready;

    pru_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .factor  (factor),
        .width   (width)
    );

    pru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .factor  (factor),
        .width   (width),
        .slot    (slot),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr)
    );

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pru_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .rd_data      (rd_data),
        .can_load     (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
